[hdl/addressable_led_strip_driver_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the LED strip driver
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_TOP_ASSERT_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_TOP_ASSERT_SVH

// same-cycle implication
`define ALSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/alsd_pkg.sv]
// ----------------------------------------------------------------------------
// alsd_pkg
// Shared types, codes and helpers of the LED strip driver.
// ----------------------------------------------------------------------------
package alsd_pkg;

  localparam int DEFAULT_MAX_LEDS = 64;
  // led_count is 7 bits wide, so no more than this many entries are reachable
  localparam int REACH_LIMIT      = 128;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 6;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = 7;
  localparam int TICK_W  = 8;
  localparam int BIT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET_ONE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_ALL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEND    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 2'd3;

  // register reset values
  localparam logic [CNT_W-1:0]  RST_LED_COUNT  = 7'd4;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 8'd5;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 8'd14;
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD = 8'd20;

  localparam logic [BIT_W-1:0] BITS_PER_PIXEL = 5'd24;
  localparam logic [BIT_W-1:0] LAST_BIT_POS   = 5'd23;

  typedef enum logic [2:0] {
    OP_SET_ONE,
    OP_SET_ALL,
    OP_CLEAR,
    OP_READ,
    OP_SEND,
    OP_TICK,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               in_range;
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] color;
  } q_entry_t;

  // front to back request
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  // live configuration, pixel count already clamped
  typedef struct packed {
    logic [CNT_W-1:0]  n;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] period;
  } cfg_t;

  // RGB word to the green, red, blue order of the line
  function automatic logic [COLOR_W-1:0] wire_order(input logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

[hdl/alsd_in_if.sv]
// ----------------------------------------------------------------------------
// alsd_in_if
// Command channel: valid/ready with command, pixel index and color.
// ----------------------------------------------------------------------------
interface alsd_in_if;
  logic                          valid;
  logic                          ready;
  logic [alsd_pkg::CMD_W-1:0]    command;
  logic [alsd_pkg::IDX_W-1:0]    pixel_index;
  logic [alsd_pkg::COLOR_W-1:0]  color;

  modport source (output valid, output command, output pixel_index, output color,
                  input ready);
  modport sink   (input valid, input command, input pixel_index, input color,
                  output ready);
endinterface

[hdl/alsd_out_if.sv]
// ----------------------------------------------------------------------------
// alsd_out_if
// Result channel: valid/ready with line level, busy, ok and read color.
// ----------------------------------------------------------------------------
interface alsd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          line_level;
  logic                          busy_res;
  logic                          ok;
  logic [alsd_pkg::COLOR_W-1:0]  read_color;

  modport source (output valid, output line_level, output busy_res, output ok,
                  output read_color, input ready);
  modport sink   (input valid, input line_level, input busy_res, input ok,
                  input read_color, output ready);
endinterface

[hdl/alsd_front.sv]
// ----------------------------------------------------------------------------
// alsd_front
// Accepts command requests, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module alsd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  alsd_in_if.sink                      in_ch,
  input  logic [alsd_pkg::CNT_W-1:0]   n,
  output alsd_pkg::q_port_t            q,
  input  logic                         q_pop
);
  import alsd_pkg::*;

  localparam int DEPTH = 2;

  q_entry_t         ent_r [DEPTH];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push;
  q_entry_t         dec;

  // decode the incoming request
  always_comb begin
    dec.pixel_index = in_ch.pixel_index;
    dec.color       = in_ch.color;
    dec.in_range    = ({1'b0, in_ch.pixel_index} < n);
    case (in_ch.command)
      CMD_SET_ONE: dec.op = OP_SET_ONE;
      CMD_SET_ALL: dec.op = OP_SET_ALL;
      CMD_CLEAR:   dec.op = OP_CLEAR;
      CMD_READ:    dec.op = OP_READ;
      CMD_SEND:    dec.op = OP_SEND;
      CMD_TICK:    dec.op = OP_TICK;
      default:     dec.op = OP_BAD;
    endcase
  end

  assign in_ch.ready = (count_r != 2'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

  assign q.valid = (count_r != 2'd0);
  assign q.entry = ent_r[rd_ptr_r];

endmodule

[hdl/alsd_back.sv]
// ----------------------------------------------------------------------------
// alsd_back
// Executes queued requests: pixel store, fill sweep, bit timing, result reg.
// ----------------------------------------------------------------------------
module alsd_back #(
  parameter int MAX_LEDS = alsd_pkg::DEFAULT_MAX_LEDS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alsd_pkg::cfg_t       cfg,
  input  alsd_pkg::q_port_t    q,
  output logic                 q_pop,
  alsd_out_if.source           out_ch
);
  import alsd_pkg::*;

  localparam int STORE_DEPTH = (MAX_LEDS < REACH_LIMIT) ? MAX_LEDS : REACH_LIMIT;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK_RD,
    S_READ_RD,
    S_SWEEP
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  logic               out_line_r;
  logic               out_busy_r;
  logic               out_ok_r;
  logic [COLOR_W-1:0] out_color_r;

  logic               sending_r, sending_nxt;
  logic               line_r;
  logic [CNT_W-1:0]   send_pixel_r, send_pixel_nxt;
  logic [BIT_W-1:0]   send_bit_r, send_bit_nxt;
  logic [TICK_W-1:0]  tick_count_r, tick_count_nxt;
  logic [CNT_W-1:0]   sweep_r;
  logic [COLOR_W-1:0] fill_r;

  // pixel store
  logic [COLOR_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [COLOR_W-1:0]     rdata_r;
  logic                   rvalid_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COLOR_W-1:0]     mem_wdata;
  logic [AW-1:0]          mem_raddr;

  logic               start;
  logic [CNT_W-1:0]   idx_ext;
  logic               frame_live;
  logic [COLOR_W-1:0] pix;
  logic [COLOR_W-1:0] word;
  logic [BIT_W-1:0]   bit_sel;
  logic [TICK_W-1:0]  high;
  logic               line_new;
  logic [TICK_W-1:0]  tick_inc;

  // take a request only when the result register is free next cycle
  assign start   = (state_r == S_IDLE) && q.valid && (!out_valid_r || out_ch.ready);
  assign q_pop   = start;
  assign idx_ext = {1'b0, q.entry.pixel_index};

  assign frame_live = sending_r && (send_pixel_r < cfg.n);

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r[AW-1:0];
    mem_wdata = fill_r;
    mem_raddr = send_pixel_r[AW-1:0];
    if (start) begin
      case (q.entry.op)
        OP_SET_ONE: begin
          if (q.entry.in_range && !sending_r) begin
            mem_we    = 1'b1;
            mem_waddr = idx_ext[AW-1:0];
            mem_wdata = q.entry.color;
          end
        end
        OP_READ:  mem_raddr = idx_ext[AW-1:0];
        default:  ;
      endcase
    end
    if (state_r == S_SWEEP) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r  <= mem[mem_raddr];
    rvalid_r <= valid_r[mem_raddr];
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_waddr] <= 1'b1;
    end
  end

  // one tick of bit timing on the pixel just read
  always_comb begin
    pix      = rvalid_r ? rdata_r : '0;
    word     = wire_order(pix);
    bit_sel  = LAST_BIT_POS - send_bit_r;
    high     = word[bit_sel] ? cfg.one_high : cfg.zero_high;
    line_new = (tick_count_r < high);
    tick_inc = tick_count_r + 8'd1;

    tick_count_nxt = tick_inc;
    send_bit_nxt   = send_bit_r;
    send_pixel_nxt = send_pixel_r;
    sending_nxt    = sending_r;
    if ((tick_inc >= cfg.period) || (tick_inc == '0)) begin
      tick_count_nxt = '0;
      send_bit_nxt   = send_bit_r + 5'd1;
      if (send_bit_nxt >= BITS_PER_PIXEL) begin
        send_bit_nxt   = '0;
        send_pixel_nxt = send_pixel_r + 7'd1;
        if (send_pixel_nxt >= cfg.n) begin
          sending_nxt = 1'b0;
        end
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      sending_r    <= 1'b0;
      line_r       <= 1'b0;
      send_pixel_r <= '0;
      send_bit_r   <= '0;
      tick_count_r <= '0;
      sweep_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            // default answer: refused, state unchanged
            out_line_r  <= line_r;
            out_busy_r  <= sending_r;
            out_ok_r    <= 1'b0;
            out_color_r <= '0;
            out_valid_r <= 1'b1;
            case (q.entry.op)
              OP_TICK: begin
                if (frame_live) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_TICK_RD;
                end else begin
                  sending_r  <= 1'b0;
                  line_r     <= 1'b0;
                  out_line_r <= 1'b0;
                  out_busy_r <= 1'b0;
                  out_ok_r   <= 1'b1;
                end
              end
              OP_SET_ONE: begin
                out_ok_r <= q.entry.in_range && !sending_r;
              end
              OP_READ: begin
                if (q.entry.in_range && !sending_r) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_READ_RD;
                end
              end
              OP_SET_ALL, OP_CLEAR: begin
                if (!sending_r) begin
                  if (cfg.n == '0) begin
                    send_pixel_r <= '0;
                    send_bit_r   <= '0;
                    tick_count_r <= '0;
                    out_ok_r     <= 1'b1;
                  end else begin
                    out_valid_r <= 1'b0;
                    fill_r      <= (q.entry.op == OP_SET_ALL) ? q.entry.color : '0;
                    sweep_r     <= '0;
                    state_r     <= S_SWEEP;
                  end
                end
              end
              OP_SEND: begin
                if (!sending_r) begin
                  send_pixel_r <= '0;
                  send_bit_r   <= '0;
                  tick_count_r <= '0;
                  sending_r    <= (cfg.n != '0);
                  out_busy_r   <= (cfg.n != '0);
                  out_ok_r     <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK_RD: begin
          line_r       <= line_new;
          tick_count_r <= tick_count_nxt;
          send_bit_r   <= send_bit_nxt;
          send_pixel_r <= send_pixel_nxt;
          sending_r    <= sending_nxt;
          out_line_r   <= line_new;
          out_busy_r   <= sending_nxt;
          out_ok_r     <= 1'b1;
          out_color_r  <= '0;
          out_valid_r  <= 1'b1;
          state_r      <= S_IDLE;
        end
        S_READ_RD: begin
          out_line_r  <= line_r;
          out_busy_r  <= sending_r;
          out_ok_r    <= 1'b1;
          out_color_r <= pix;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_SWEEP: begin
          sweep_r <= sweep_r + 7'd1;
          // last entry written: start the frame
          if (sweep_r == cfg.n - 7'd1) begin
            send_pixel_r <= '0;
            send_bit_r   <= '0;
            tick_count_r <= '0;
            sending_r    <= 1'b1;
            out_line_r   <= line_r;
            out_busy_r   <= 1'b1;
            out_ok_r     <= 1'b1;
            out_color_r  <= '0;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_level = out_line_r;
  assign out_ch.busy_res   = out_busy_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.read_color = out_color_r;

endmodule

[hdl/addressable_led_strip_driver_top.sv]
// ----------------------------------------------------------------------------
// addressable_led_strip_driver_top
// One-wire LED strip driver: pixel store, frame sender and register file.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command request per handshake (set one, set all, clear,
//   read one, send, tick). Every request gives exactly one result on out_ch:
//   the line level, busy flag, ok flag and read-back color.
//   cfg_we/cfg_index/cfg_wdata write led_count, zero/one high ticks and the
//   bit period; write them only while no request is outstanding.
// Sequencing:
//   A two-entry queue feeds the executor, which handles one request at a
//   time. Set one, send, idle ticks and refused requests are answered from
//   the idle state; a tick during a frame and an in-range read one go
//   through a read state (registered store read); set all and clear sweep
//   the clamped led_count entries, one store entry written per cycle.
// Reset:
//   Registers return to their defaults, no frame is sending, the line is
//   low and every pixel reads as zero (per-entry valid flags).
// Stall:
//   While out_ch is stalled the result register holds and the queue fills;
//   in_ch.ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module addressable_led_strip_driver_top #(
  parameter int MAX_LEDS = alsd_pkg::DEFAULT_MAX_LEDS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  alsd_in_if.sink                           in_ch,
  alsd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [alsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [alsd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import alsd_pkg::*;

  localparam int STORE_DEPTH = (MAX_LEDS < REACH_LIMIT) ? MAX_LEDS : REACH_LIMIT;
  localparam logic [CNT_W:0] CAP = (CNT_W+1)'(STORE_DEPTH);

  logic [CNT_W-1:0]  led_count_r;
  logic [TICK_W-1:0] zero_high_r;
  logic [TICK_W-1:0] one_high_r;
  logic [TICK_W-1:0] bit_period_r;
  cfg_t              cfg;
  q_port_t           q;
  logic              q_pop;
  logic              refused_out;
  logic              count_we;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r  <= RST_LED_COUNT;
      zero_high_r  <= RST_ZERO_HIGH;
      one_high_r   <= RST_ONE_HIGH;
      bit_period_r <= RST_BIT_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LED_COUNT:  led_count_r  <= cfg_wdata[CNT_W-1:0];
        REG_ZERO_HIGH:  zero_high_r  <= cfg_wdata;
        REG_ONE_HIGH:   one_high_r   <= cfg_wdata;
        REG_BIT_PERIOD: bit_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pixel count clamped to the store depth
  assign cfg.n         = ({1'b0, led_count_r} > CAP) ? CAP[CNT_W-1:0] : led_count_r;
  assign cfg.zero_high = zero_high_r;
  assign cfg.one_high  = one_high_r;
  assign cfg.period    = bit_period_r;

  alsd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .n     (cfg.n),
    .q     (q),
    .q_pop (q_pop)
  );

  alsd_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .q      (q),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // checks
  assign refused_out = out_ch.valid && !out_ch.ok;
  assign count_we    = cfg_we && (cfg_index == REG_LED_COUNT);

`include "addressable_led_strip_driver_top_assert.svh"

  `ALSD_ASSERT_IMP(a_pop_needs_entry, q_pop, q.valid, "queue popped while empty")
  `ALSD_ASSERT_IMP(a_refused_no_color, refused_out, out_ch.read_color == '0, "refusal with color")
  `ALSD_ASSERT_IMP(a_count_clamped, 1'b1, {1'b0, cfg.n} <= CAP, "pixel count above store depth")
  `ALSD_ASSERT_NXT(a_count_write, count_we, led_count_r == $past(cfg_wdata[CNT_W-1:0]), "count lost")

endmodule
